[sv/tts_pkg.sv]
// Package with the coordinate types, vertex index codes and trapezoid records of the splitter.
package tts_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic [1:0]                    vidx_t;

	localparam vidx_t VTX_FIRST  = 2'd0;
	localparam vidx_t VTX_SECOND = 2'd1;
	localparam vidx_t VTX_THIRD  = 2'd2;

	// One trapezoid as it leaves the block.
	typedef struct packed {
		coord_t top_y;
		coord_t bottom_y;
		vidx_t  left_start;
		vidx_t  left_end;
		vidx_t  right_start;
		vidx_t  right_end;
		logic   last_piece;
	} trap_t;

	// All trapezoids of one triangle; p1 is meaningful only when two is set.
	typedef struct packed {
		logic  two;
		trap_t p0;
		trap_t p1;
	} trap_pair_t;

	function automatic trap_t make_trap(coord_t top, coord_t bot, vidx_t ls, vidx_t le,
			vidx_t rs, vidx_t re, logic last);
		trap_t t;
		t.top_y       = top;
		t.bottom_y    = bot;
		t.left_start  = ls;
		t.left_end    = le;
		t.right_start = rs;
		t.right_end   = re;
		t.last_piece  = last;
		return t;
	endfunction

endpackage

[sv/tts_if.sv]
// Interfaces of the triangle input channel and the trapezoid output channel.
interface tts_tri_if;
	import tts_pkg::*;
	logic   valid;
	logic   ready;
	coord_t first_x;
	coord_t first_y;
	coord_t second_x;
	coord_t second_y;
	coord_t third_x;
	coord_t third_y;

	modport source(output valid, output first_x, output first_y, output second_x,
		output second_y, output third_x, output third_y, input ready);
	modport sink(input valid, input first_x, input first_y, input second_x,
		input second_y, input third_x, input third_y, output ready);
endinterface

interface tts_trap_if;
	import tts_pkg::*;
	logic   valid;
	logic   ready;
	coord_t top_y;
	coord_t bottom_y;
	vidx_t  left_start;
	vidx_t  left_end;
	vidx_t  right_start;
	vidx_t  right_end;
	logic   last_piece;

	modport source(output valid, output top_y, output bottom_y, output left_start,
		output left_end, output right_start, output right_end, output last_piece,
		input ready);
	modport sink(input valid, input top_y, input bottom_y, input left_start,
		input left_end, input right_start, input right_end, input last_piece,
		output ready);
endinterface

[sv/triangle_trapezoid_split_unit.sv]
// Top level of the triangle setup unit that splits triangles into trapezoids.
// Each input transaction carries one triangle as three signed 16-bit vertices (4 fraction
// bits, compared as raw integers). The unit sorts the vertices by y, drops triangles whose
// vertices all share one y or all share one x, and emits one trapezoid for a flat-top or
// flat-bottom triangle or two trapezoids, split at the middle vertex, for any other one.
// Edges are reported as input vertex indices; last_piece marks the final trapezoid of each
// triangle. The left/right decision uses exact 34-bit cross products, so collinear but
// non-axis-aligned triangles are split normally. A triangle passes a four-stage pipeline
// (sort, classify and edge differences, cross products, side test) and then the output
// register, from which its first trapezoid is presented on the output. A new triangle can
// be accepted every cycle while the output does not hold the pipeline; the sustained rate
// is set by the output channel, which moves one trapezoid per cycle, so single-trapezoid
// triangles flow at one per cycle and a split triangle keeps the channel for both of its
// trapezoids before the next triangle is loaded. Degenerate triangles take a pipeline slot
// and produce nothing. The output register and a one-entry holding register for the second
// trapezoid decouple the two sides, and a stall on the output freezes the pipeline without
// loss. There is no configuration and no state beyond the pipeline; reset only empties it.
module triangle_trapezoid_split_unit (
	input  logic       clk,
	input  logic       arst_n,
	tts_tri_if.sink    in,
	tts_trap_if.source out
);
	import tts_pkg::*;

	// Handshake between the setup pipeline and the output stage; one transaction holds
	// every trapezoid of a triangle.
	logic       pair_valid;
	logic       pair_ready;
	trap_pair_t pair;

	tts_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in         (in),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready),
		.pair       (pair)
	);

	tts_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready),
		.pair       (pair),
		.out        (out)
	);

endmodule

[sv/tts_pipe.sv]
// Four-stage setup pipeline: sort, classify, cross products, side test and trapezoid build.
module tts_pipe (
	input  logic                clk,
	input  logic                arst_n,
	tts_tri_if.sink             in,
	output logic                pair_valid,
	input  logic                pair_ready,
	output tts_pkg::trap_pair_t pair
);
	import tts_pkg::*;

	typedef struct packed {
		coord_t x;
		coord_t y;
		vidx_t  idx;
	} vert_t;

	logic adv;

	// Stage 1 registers: vertices sorted by y.
	logic  valid_s1;
	vert_t va_s1, vb_s1, vc_s1;
	// Stage 2 registers: classification and edge differences.
	logic  valid_s2;
	vert_t va_s2, vb_s2, vc_s2;
	logic  flat_s2;
	trap_t flat_trap_s2;
	diff_t dxb_s2, dyc_s2, dxc_s2, dyb_s2;
	// Stage 3 registers: cross products.
	logic  valid_s3;
	vert_t va_s3, vb_s3, vc_s3;
	logic  flat_s3;
	trap_t flat_trap_s3;
	prod_t lp_s3, rp_s3;
	// Stage 4 registers: finished trapezoids.
	logic       valid_s4;
	trap_pair_t pair_s4;

	vert_t sa, sb, sc, st;
	logic  all_y_eq, all_x_eq, flat_top, flat_bot;
	trap_t flat_trap;
	logic  left_ab;
	trap_pair_t pair_d;

	assign adv      = !valid_s4 || pair_ready;
	assign in.ready = adv;

	// Three-way compare-and-swap on y (not stable for vertices with equal y).
	always_comb begin
		sa = '{x: in.first_x,  y: in.first_y,  idx: VTX_FIRST};
		sb = '{x: in.second_x, y: in.second_y, idx: VTX_SECOND};
		sc = '{x: in.third_x,  y: in.third_y,  idx: VTX_THIRD};
		st = sa;
		if (sa.y > sb.y) begin
			st = sa; sa = sb; sb = st;
		end
		if (sa.y > sc.y) begin
			st = sa; sa = sc; sc = st;
		end
		if (sb.y > sc.y) begin
			st = sb; sb = sc; sc = st;
		end
	end

	// Degenerate and flat detection; a flat triangle is fully resolved here.
	always_comb begin
		all_y_eq = (va_s1.y == vb_s1.y) && (va_s1.y == vc_s1.y);
		all_x_eq = (va_s1.x == vb_s1.x) && (va_s1.x == vc_s1.x);
		flat_top = (va_s1.y == vb_s1.y);
		flat_bot = (vb_s1.y == vc_s1.y);
		if (flat_top) begin
			if (va_s1.x > vb_s1.x) begin
				flat_trap = make_trap(va_s1.y, vc_s1.y, vb_s1.idx, vc_s1.idx,
					va_s1.idx, vc_s1.idx, 1'b1);
			end else begin
				flat_trap = make_trap(va_s1.y, vc_s1.y, va_s1.idx, vc_s1.idx,
					vb_s1.idx, vc_s1.idx, 1'b1);
			end
		end else if (vb_s1.x > vc_s1.x) begin
			flat_trap = make_trap(va_s1.y, vc_s1.y, va_s1.idx, vc_s1.idx,
				va_s1.idx, vb_s1.idx, 1'b1);
		end else begin
			flat_trap = make_trap(va_s1.y, vc_s1.y, va_s1.idx, vb_s1.idx,
				va_s1.idx, vc_s1.idx, 1'b1);
		end
	end

	// Side test on the exact cross products, then the split at the middle vertex.
	always_comb begin
		left_ab   = (lp_s3 <= rp_s3);
		pair_d    = '0;
		if (flat_s3) begin
			pair_d.two = 1'b0;
			pair_d.p0  = flat_trap_s3;
			pair_d.p1  = flat_trap_s3;
		end else if (left_ab) begin
			pair_d.two = 1'b1;
			pair_d.p0  = make_trap(va_s3.y, vb_s3.y, va_s3.idx, vb_s3.idx,
				va_s3.idx, vc_s3.idx, 1'b0);
			pair_d.p1  = make_trap(vb_s3.y, vc_s3.y, vb_s3.idx, vc_s3.idx,
				va_s3.idx, vc_s3.idx, 1'b1);
		end else begin
			pair_d.two = 1'b1;
			pair_d.p0  = make_trap(va_s3.y, vb_s3.y, va_s3.idx, vc_s3.idx,
				va_s3.idx, vb_s3.idx, 1'b0);
			pair_d.p1  = make_trap(vb_s3.y, vc_s3.y, va_s3.idx, vc_s3.idx,
				vb_s3.idx, vc_s3.idx, 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in.valid;
			valid_s2 <= valid_s1 && !all_y_eq && !all_x_eq;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			va_s1        <= sa;
			vb_s1        <= sb;
			vc_s1        <= sc;
			va_s2        <= va_s1;
			vb_s2        <= vb_s1;
			vc_s2        <= vc_s1;
			flat_s2      <= flat_top || flat_bot;
			flat_trap_s2 <= flat_trap;
			dxb_s2       <= diff_t'(vb_s1.x) - diff_t'(va_s1.x);
			dyc_s2       <= diff_t'(vc_s1.y) - diff_t'(va_s1.y);
			dxc_s2       <= diff_t'(vc_s1.x) - diff_t'(va_s1.x);
			dyb_s2       <= diff_t'(vb_s1.y) - diff_t'(va_s1.y);
			va_s3        <= va_s2;
			vb_s3        <= vb_s2;
			vc_s3        <= vc_s2;
			flat_s3      <= flat_s2;
			flat_trap_s3 <= flat_trap_s2;
			lp_s3        <= prod_t'(dxb_s2) * prod_t'(dyc_s2);
			rp_s3        <= prod_t'(dxc_s2) * prod_t'(dyb_s2);
			pair_s4      <= pair_d;
		end
	end

	assign pair_valid = valid_s4;
	assign pair       = pair_s4;

`ifndef NO_ASSERTIONS
	a_no_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !((va_s2.y == vb_s2.y) && (va_s2.y == vc_s2.y)))
		else $error("degenerate triangle passed classification");
	a_two_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && pair_s4.two) |-> (!pair_s4.p0.last_piece && pair_s4.p1.last_piece))
		else $error("split triangle carries wrong last flags");
	a_one_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !pair_s4.two) |-> pair_s4.p0.last_piece)
		else $error("single trapezoid not marked last");
`endif

endmodule

[sv/tts_emit.sv]
// Output stage that hands out the one or two trapezoids of a triangle, one per transaction.
module tts_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pair_valid,
	output logic                pair_ready,
	input  tts_pkg::trap_pair_t pair,
	tts_trap_if.source          out
);
	import tts_pkg::*;

	logic  cur_vld_q, pend_vld_q;
	trap_t cur_q, pend_q;
	logic  take, load;

	assign take       = cur_vld_q && out.ready;
	assign pair_ready = !pend_vld_q && (!cur_vld_q || out.ready);
	assign load       = pair_valid && pair_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else if (load) begin
			cur_vld_q  <= 1'b1;
			pend_vld_q <= pair.two;
		end else if (take) begin
			cur_vld_q  <= pend_vld_q;
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q  <= pair.p0;
			pend_q <= pair.p1;
		end else if (take && pend_vld_q) begin
			cur_q  <= pend_q;
		end
	end

	assign out.valid       = cur_vld_q;
	assign out.top_y       = cur_q.top_y;
	assign out.bottom_y    = cur_q.bottom_y;
	assign out.left_start  = cur_q.left_start;
	assign out.left_end    = cur_q.left_end;
	assign out.right_start = cur_q.right_start;
	assign out.right_end   = cur_q.right_end;
	assign out.last_piece  = cur_q.last_piece;

`ifndef NO_ASSERTIONS
	a_pend_needs_cur: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> cur_vld_q)
		else $error("second trapezoid waiting without a first");
	a_first_has_second: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_vld_q && !cur_q.last_piece) |-> pend_vld_q)
		else $error("non-final trapezoid shown without its successor queued");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_vld_q && !out.ready) |=> (cur_vld_q && $stable(cur_q)))
		else $error("stalled trapezoid changed before it was taken");
`endif

endmodule
